### design/fifo_page_credit_admission_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page-credit admission controller
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef FIFO_PAGE_CREDIT_ADMISSION_DEFINES_SVH
`define FIFO_PAGE_CREDIT_ADMISSION_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define FPCA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpca assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define FPCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpca assertion failed");
`else
`define FPCA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define FPCA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### design/fpca_pkg.sv
// ----------------------------------------------------------------------------
// fpca_pkg
// Types and constants shared by the page-credit admission controller.
// ----------------------------------------------------------------------------
package fpca_pkg;

  // Default number of waiter queue entries.
  localparam int unsigned WaiterDepthDefault = 16;

  // Pool size after reset.
  localparam logic [15:0] CapacityReset = 16'd256;

  // Byte address of the capacity register.
  localparam logic [1:0] AddrCapacity = 2'd0;

  // Request kinds.
  typedef enum logic [2:0] {
    KIND_ACQ_WAIT = 3'd0,
    KIND_ACQ_TRY  = 3'd1,
    KIND_RELEASE  = 3'd2,
    KIND_CLOSE    = 3'd3,
    KIND_BREAK    = 3'd4
  } kind_t;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_GRANTED  = 4'd0,
    ST_OK_ZERO  = 4'd1,
    ST_QUEUED   = 4'd2,
    ST_NO_SPACE = 4'd3,
    ST_NOT_FIT  = 4'd4,
    ST_STOPPED  = 4'd5,
    ST_BROKEN   = 4'd6,
    ST_DONE     = 4'd7,
    ST_OVERFLOW = 4'd8,
    ST_QFULL    = 4'd9
  } status_t;

  // One waiter queue entry.
  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] need;
  } waiter_t;

endpackage

### design/fifo_page_credit_admission.sv
// Acquire, try-acquire, a zero release, a repeated close and unused kinds: one result
// registered in the cycle after start; busy stays low. Other release, close and break:
// a walk of any waiters, each through a queue memory read state and a check state, then
// a final state that gives the last result; busy is high meanwhile.
// Results are one-cycle strobes that the receiver cannot stall.
// Synchronous reset: capacity and free pages 256, flags clear, queue empty.
// ----------------------------------------------------------------------------
// fifo_page_credit_admission
// Page-credit admission controller with a strict-FIFO waiter queue held in
// a synchronous memory and walked one entry at a time on release and flush.
// ----------------------------------------------------------------------------
`include "fifo_page_credit_admission_defines.svh"

module fifo_page_credit_admission
  import fpca_pkg::*;
#(
  parameter int unsigned WAITER_DEPTH = WaiterDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  // Command channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [15:0] count,
  input  logic [7:0]  requester,
  // Result channel
  output logic        valid,
  output logic [7:0]  requester_res,
  output logic [3:0]  status,
  output logic [15:0] granted_pages,
  output logic        pressure,
  output logic        last,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IDX_W  = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(WAITER_DEPTH + 1);
  localparam int unsigned SUM_W  = IDX_W + 2;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CHECK, S_FINAL} state_t;

  state_t              state;
  logic [15:0]         capacity_pages;
  logic [15:0]         free_pages;
  logic                closed_flag;
  logic                broken_flag;
  logic [IDX_W-1:0]    queue_head;
  logic [FILL_W-1:0]   queue_fill;
  logic                op_flush;
  status_t             flush_status;
  status_t             fin_status;
  logic                fin_press_en;
  logic [7:0]          op_tag;

  waiter_t             queue_mem [WAITER_DEPTH];
  waiter_t             rd_entry;

  logic                cfg_we;
  logic                accept;
  logic                is_wait;
  logic                imm_emit;
  status_t             imm_status;
  logic [15:0]         imm_pages;
  logic                imm_press;
  logic                acq_grant;
  logic                acq_push;
  logic [16:0]         credit_sum;
  logic                credit_over;
  logic [15:0]         credit_free;
  logic [SUM_W-1:0]    tail_sum;
  logic [IDX_W-1:0]    tail_idx;
  logic [IDX_W-1:0]    head_inc;
  logic                queue_empty;
  logic                queue_full;
  logic                last_waiter;

  // Configuration port: single register, pready tied high.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr == AddrCapacity) ? {16'd0, capacity_pages} : 32'd0;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Queue pointer arithmetic with wrap at a possibly non-power-of-two depth.
  assign queue_empty = (queue_fill == '0);
  assign queue_full  = (queue_fill >= FILL_W'(WAITER_DEPTH));
  assign last_waiter = (queue_fill == FILL_W'(1));
  assign tail_sum    = SUM_W'(queue_head) + SUM_W'(queue_fill);
  assign tail_idx    = (tail_sum >= SUM_W'(WAITER_DEPTH)) ?
                       IDX_W'(tail_sum - SUM_W'(WAITER_DEPTH)) : IDX_W'(tail_sum);
  assign head_inc    = (queue_head == IDX_W'(WAITER_DEPTH - 1)) ? '0 : queue_head + 1'b1;

  // Credit return, saturating at capacity.
  assign credit_sum  = {1'b0, free_pages} + {1'b0, count};
  assign credit_over = (credit_sum > {1'b0, capacity_pages});
  assign credit_free = credit_over ? capacity_pages : credit_sum[15:0];

  // Decide the result of commands that finish in the accepting cycle.
  always_comb begin
    is_wait    = (kind == KIND_ACQ_WAIT);
    imm_emit   = 1'b1;
    imm_status = ST_DONE;
    imm_pages  = 16'd0;
    imm_press  = 1'b0;
    acq_grant  = 1'b0;
    acq_push   = 1'b0;
    case (kind_t'(kind))
      KIND_ACQ_WAIT, KIND_ACQ_TRY: begin
        if (count == 16'd0) begin
          imm_status = ST_OK_ZERO;
        end else if (count > capacity_pages) begin
          imm_status = is_wait ? ST_NO_SPACE : ST_NOT_FIT;
        end else if (broken_flag) begin
          imm_status = ST_BROKEN;
        end else if (closed_flag) begin
          imm_status = ST_STOPPED;
        end else if (queue_empty && (free_pages >= count)) begin
          imm_status = ST_GRANTED;
          imm_pages  = count;
          acq_grant  = 1'b1;
        end else if (!is_wait) begin
          imm_status = ST_NOT_FIT;
        end else if (queue_full) begin
          imm_status = ST_QFULL;
        end else begin
          imm_status = ST_QUEUED;
          imm_press  = queue_empty;
          acq_push   = 1'b1;
        end
      end
      KIND_RELEASE: imm_emit = (count == 16'd0);
      KIND_CLOSE:   imm_emit = closed_flag;
      KIND_BREAK:   imm_emit = 1'b0;
      default:      imm_emit = 1'b1;
    endcase
  end

  // Waiter queue memory: one write port, registered read at the head.
  always_ff @(posedge clk) begin
    if (accept && acq_push) begin
      queue_mem[tail_idx] <= '{tag: requester, need: count};
    end
    rd_entry <= queue_mem[queue_head];
  end

  // Sequencer, pool state and registered results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      capacity_pages <= CapacityReset;
      free_pages     <= CapacityReset;
      closed_flag    <= 1'b0;
      broken_flag    <= 1'b0;
      queue_head     <= '0;
      queue_fill     <= '0;
      valid          <= 1'b0;
    end else begin
      valid <= 1'b0;
      if (cfg_we) begin
        capacity_pages <= pwdata[15:0];
        free_pages     <= pwdata[15:0];
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_tag        <= requester;
            valid         <= imm_emit;
            requester_res <= requester;
            status        <= imm_status;
            granted_pages <= imm_pages;
            pressure      <= imm_press;
            last          <= 1'b1;
            if (acq_grant) begin
              free_pages <= free_pages - count;
            end
            if (acq_push) begin
              queue_fill <= queue_fill + 1'b1;
            end
            if (!imm_emit) begin
              case (kind_t'(kind))
                KIND_RELEASE: begin
                  free_pages   <= credit_free;
                  op_flush     <= 1'b0;
                  fin_status   <= credit_over ? ST_OVERFLOW : ST_DONE;
                  fin_press_en <= !queue_empty;
                  state        <= (!queue_empty && !closed_flag && !broken_flag) ?
                                  S_READ : S_FINAL;
                end
                KIND_CLOSE: begin
                  closed_flag  <= 1'b1;
                  op_flush     <= 1'b1;
                  flush_status <= ST_STOPPED;
                  fin_status   <= ST_DONE;
                  fin_press_en <= 1'b0;
                  state        <= queue_empty ? S_FINAL : S_READ;
                end
                KIND_BREAK: begin
                  free_pages   <= credit_free;
                  broken_flag  <= 1'b1;
                  op_flush     <= 1'b1;
                  flush_status <= ST_BROKEN;
                  fin_status   <= credit_over ? ST_OVERFLOW : ST_DONE;
                  fin_press_en <= 1'b0;
                  state        <= queue_empty ? S_FINAL : S_READ;
                end
                default: state <= S_IDLE;
              endcase
            end
          end
        end
        // Head entry is being read out of the memory.
        S_READ: begin
          state <= S_CHECK;
        end
        // Grant or fail the head waiter, or stop when it no longer fits.
        S_CHECK: begin
          if (op_flush || (free_pages >= rd_entry.need)) begin
            valid         <= 1'b1;
            requester_res <= rd_entry.tag;
            status        <= op_flush ? flush_status : ST_GRANTED;
            granted_pages <= op_flush ? 16'd0 : rd_entry.need;
            pressure      <= 1'b0;
            last          <= 1'b0;
            if (!op_flush) begin
              free_pages <= free_pages - rd_entry.need;
            end
            queue_head <= head_inc;
            queue_fill <= queue_fill - 1'b1;
            state      <= last_waiter ? S_FINAL : S_READ;
          end else begin
            state <= S_FINAL;
          end
        end
        // Closing beat of a release, close or break, after any walk.
        S_FINAL: begin
          valid         <= 1'b1;
          requester_res <= op_tag;
          status        <= fin_status;
          granted_pages <= 16'd0;
          pressure      <= fin_press_en && !queue_empty;
          last          <= 1'b1;
          if (op_flush) begin
            queue_head <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on queue bookkeeping and result sequencing.
  `FPCA_ASSERT_IMPLY(a_fill_bound, clk, rst, 1'b1, queue_fill <= FILL_W'(WAITER_DEPTH))
  `FPCA_ASSERT_IMPLY(a_free_bound, clk, rst, 1'b1, free_pages <= capacity_pages)
  `FPCA_ASSERT_IMPLY(a_last_idle, clk, rst, valid && last, !busy)
  `FPCA_ASSERT_IMPLY(a_queued_fill, clk, rst, valid && (status == ST_QUEUED), !queue_empty)

endmodule
